/* rtl/core/bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // Temperature and pressure limits, all in output units
   localparam int TEMP_REF = 2000;
   localparam int TEMP_LOW = -1500;
   localparam int TEMP_MIN = -4000;
   localparam int TEMP_MAX = 8500;
   localparam int PRES_MIN = 1000;
   localparam int PRES_MAX = 120000;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // Calibration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS        = 8'd0,
      CSR_OFFSET      = 8'd1,
      CSR_SENS_TEMP   = 8'd2,
      CSR_OFFSET_TEMP = 8'd3,
      CSR_REF_TEMP    = 8'd4,
      CSR_TEMP_SLOPE  = 8'd5
   } csr_idx_type;

   // Six factory calibration words
   typedef struct packed {
      logic [15:0] sens;
      logic [15:0] offset;
      logic [15:0] sens_temp;
      logic [15:0] offset_temp;
      logic [15:0] ref_temp;
      logic [15:0] temp_slope;
   } coef_type;

   // First-order results
   typedef struct packed {
      logic        [23:0] d1;
      logic signed [18:0] temp;
      logic signed [35:0] off;
      logic signed [34:0] sens;
      logic        [17:0] t2;
   } front_type;

   // Second-order corrected values
   typedef struct packed {
      logic        [23:0] d1;
      logic signed [14:0] temp;
      logic signed [39:0] off;
      logic signed [38:0] sens;
   } corr_type;

endpackage

/* rtl/core/bsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_front
// Three stages: temperature difference, coefficient products, first-order
// temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bsc_front (
   input  logic                clock,
   input  logic                reset,
   input  bsc_pkg::coef_type   coef,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [23:0]         in_raw_pressure,
   input  logic [23:0]         in_raw_temperature,
   output logic                out_valid,
   input  logic                out_stall,
   output bsc_pkg::front_type  out_data
);

   logic [2:0] vld_ff, vld_in;
   logic [2:0] adv;

   logic        [23:0] d1_s1_ff, d1_s2_ff;
   logic signed [24:0] dt_in, dt_ff;
   logic signed [41:0] p6_in, p6_ff;
   logic signed [41:0] p4_in, p4_ff;
   logic signed [41:0] p3_in, p3_ff;
   logic signed [48:0] sq_in, sq_ff;
   bsc_pkg::front_type out_in, out_ff;

   // Stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      adv[2]    = !vld_ff[2] || !out_stall;
      adv[1]    = !vld_ff[1] || adv[2];
      adv[0]    = !vld_ff[0] || adv[1];
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // dT = D2 - C5 * 2^8
   assign dt_in = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, coef.ref_temp, 8'h00});

   // Products with dT, one multiplier each
   assign p6_in = dt_ff * $signed({1'b0, coef.temp_slope});
   assign p4_in = dt_ff * $signed({1'b0, coef.offset_temp});
   assign p3_in = dt_ff * $signed({1'b0, coef.sens_temp});
   assign sq_in = dt_ff * dt_ff;

   // First-order values; the shifts are floor shifts on the products
   always_comb begin
      out_in.d1   = d1_s2_ff;
      out_in.temp = 19'(bsc_pkg::TEMP_REF) + $signed(p6_ff[41:23]);
      out_in.off  = $signed({4'b0, coef.offset, 16'h0000}) + $signed(p4_ff[41:7]);
      out_in.sens = $signed({4'b0, coef.sens, 15'h0000}) + $signed(p3_ff[41:8]);
      out_in.t2   = sq_ff[48:31];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d1_s1_ff <= in_raw_pressure;
         dt_ff    <= dt_in;
      end
      if (adv[1]) begin
         d1_s2_ff <= d1_s1_ff;
         p6_ff    <= p6_in;
         p4_ff    <= p4_in;
         p3_ff    <= p3_in;
         sq_ff    <= sq_in;
      end
      if (adv[2]) begin
         out_ff <= out_in;
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = out_ff;

endmodule

/* rtl/core/bsc_corr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_corr
// Three stages of second-order low-temperature correction and the output
// temperature clamp.
// ----------------------------------------------------------------------------
module bsc_corr (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  bsc_pkg::front_type  in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output bsc_pkg::corr_type   out_data
);

   logic [2:0] vld_ff, vld_in;
   logic [2:0] adv;

   // Stage 4
   logic signed [18:0] tdiff;
   logic signed [19:0] tlow;
   logic        [34:0] a_in, a_ff;
   logic        [34:0] b_in, b_ff;
   logic               lt_ref_ff, lt_low_ff;
   logic        [23:0] d1_s4_ff;
   logic signed [18:0] temp_s4_ff;
   logic signed [35:0] off_s4_ff;
   logic signed [34:0] sens_s4_ff;
   logic        [17:0] t2_s4_ff;

   // Stage 5
   logic        [37:0] a5, b7, b11;
   logic        [37:0] off2_in, off2_ff;
   logic        [36:0] sens2_in, sens2_ff;
   logic signed [19:0] temp_f;
   logic signed [14:0] temp_c_in, temp_c_ff;
   logic        [23:0] d1_s5_ff;
   logic signed [35:0] off_s5_ff;
   logic signed [34:0] sens_s5_ff;

   // Stage 6
   bsc_pkg::corr_type  out_in, out_ff;

   always_comb begin
      adv[2]    = !vld_ff[2] || !out_stall;
      adv[1]    = !vld_ff[1] || adv[2];
      adv[0]    = !vld_ff[0] || adv[1];
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Squares of the distance below 20.00 and below -15.00 degC
   always_comb begin
      tdiff = $signed(in_data.temp) - 19'(bsc_pkg::TEMP_REF);
      tlow  = 20'($signed(in_data.temp)) - 20'(bsc_pkg::TEMP_LOW);
      a_in  = 35'(tdiff * tdiff);
      b_in  = 35'(tlow * tlow);
   end

   // OFF2 = 5a/2 + 7b, SENS2 = 5a/4 + 11b/2, each part truncated
   always_comb begin
      a5  = 38'(a_ff) + (38'(a_ff) << 2);
      b7  = (38'(b_ff) << 3) - 38'(b_ff);
      b11 = (38'(b_ff) << 3) + (38'(b_ff) << 1) + 38'(b_ff);
      off2_in  = '0;
      sens2_in = '0;
      if (lt_ref_ff) begin
         off2_in  = (a5 >> 1) + (lt_low_ff ? b7 : 38'd0);
         sens2_in = 37'((a5 >> 2) + (lt_low_ff ? (b11 >> 1) : 38'd0));
      end
   end

   // Final temperature and its clamp
   always_comb begin
      temp_f = 20'(temp_s4_ff) - $signed({2'b00, (lt_ref_ff ? t2_s4_ff : 18'd0)});
      priority if (temp_f < bsc_pkg::TEMP_MIN) begin
         temp_c_in = 15'(bsc_pkg::TEMP_MIN);
      end else if (temp_f > bsc_pkg::TEMP_MAX) begin
         temp_c_in = 15'(bsc_pkg::TEMP_MAX);
      end else begin
         temp_c_in = temp_f[14:0];
      end
   end

   // Corrected offset and sensitivity
   always_comb begin
      out_in.d1   = d1_s5_ff;
      out_in.temp = temp_c_ff;
      out_in.off  = off_s5_ff - $signed({2'b00, off2_ff});
      out_in.sens = sens_s5_ff - $signed({2'b00, sens2_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff       <= a_in;
         b_ff       <= b_in;
         lt_ref_ff  <= tdiff[18];
         lt_low_ff  <= tlow[19];
         d1_s4_ff   <= in_data.d1;
         temp_s4_ff <= in_data.temp;
         off_s4_ff  <= in_data.off;
         sens_s4_ff <= in_data.sens;
         t2_s4_ff   <= in_data.t2;
      end
      if (adv[1]) begin
         off2_ff    <= off2_in;
         sens2_ff   <= sens2_in;
         temp_c_ff  <= temp_c_in;
         d1_s5_ff   <= d1_s4_ff;
         off_s5_ff  <= off_s4_ff;
         sens_s5_ff <= sens_s4_ff;
      end
      if (adv[2]) begin
         out_ff <= out_in;
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = out_ff;

endmodule

/* rtl/core/bsc_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_press
// Four stages: split D1 * SENS product, partial product sum, offset
// subtract, final shift and pressure clamp into the output register.
// ----------------------------------------------------------------------------
module bsc_press (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  bsc_pkg::corr_type  in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output logic signed [14:0] out_temperature_centi,
   output logic        [16:0] out_pressure_pascal
);

   logic [3:0] vld_ff, vld_in;
   logic [3:0] adv;

   logic        [43:0] pl_in, pl_ff;
   logic signed [43:0] ph_in, ph_ff;
   logic signed [63:0] prod_in, prod_ff;
   logic signed [43:0] y_in, y_ff;
   logic signed [28:0] p;
   logic        [16:0] pres_in, pres_ff;
   logic signed [39:0] off_s7_ff, off_s8_ff;
   logic signed [14:0] temp_s7_ff, temp_s8_ff, temp_s9_ff, temp_ff;

   always_comb begin
      adv[3]    = !vld_ff[3] || !out_stall;
      adv[2]    = !vld_ff[2] || adv[3];
      adv[1]    = !vld_ff[1] || adv[2];
      adv[0]    = !vld_ff[0] || adv[1];
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = adv[3] ? vld_ff[2] : vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // SENS split into signed high and unsigned low 20 bits
   assign pl_in = in_data.d1 * in_data.sens[19:0];
   assign ph_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[38:20]);

   // Recombine partial products
   assign prod_in = $signed({ph_ff, 20'h00000}) + $signed({20'h00000, pl_ff});

   // (D1 * SENS >> 21) - OFF
   assign y_in = $signed(prod_ff[63:21]) - off_s8_ff;

   // >> 15 and clamp
   always_comb begin
      p = $signed(y_ff[43:15]);
      priority if (p < bsc_pkg::PRES_MIN) begin
         pres_in = 17'(bsc_pkg::PRES_MIN);
      end else if (p > bsc_pkg::PRES_MAX) begin
         pres_in = 17'(bsc_pkg::PRES_MAX);
      end else begin
         pres_in = p[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pl_ff      <= pl_in;
         ph_ff      <= ph_in;
         off_s7_ff  <= in_data.off;
         temp_s7_ff <= in_data.temp;
      end
      if (adv[1]) begin
         prod_ff    <= prod_in;
         off_s8_ff  <= off_s7_ff;
         temp_s8_ff <= temp_s7_ff;
      end
      if (adv[2]) begin
         y_ff       <= y_in;
         temp_s9_ff <= temp_s8_ff;
      end
      if (adv[3]) begin
         pres_ff <= pres_in;
         temp_ff <= temp_s9_ff;
      end
   end

   assign in_stall              = !adv[0];
   assign out_valid             = vld_ff[3];
   assign out_temperature_centi = temp_ff;
   assign out_pressure_pascal   = pres_ff;

endmodule

/* rtl/core/baro_sensor_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Converts one pair of raw 24-bit pressure and temperature ADC words into
// temperature in 0.01 degC (clamped to -4000..8500) and pressure in pascals
// (clamped to 1000..120000), with first-order compensation and second-order
// correction below 20.00 degC and again below -15.00 degC. The six
// calibration words are written through the csr port (index 0..5: C1..C6,
// other indexes ignored, reset value 0); the user must write them only while
// no word is in flight, which the block does not enforce. The datapath is a
// ten-stage pipeline that accepts one word every cycle while req_stall is
// low; each word's result is presented on the rsp port from the last stage
// register. Each stage holds its word until the next stage frees, so
// rsp_stall only backs up into req_stall once all ten stages are full.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [23:0]                    req_raw_pressure,
   input  logic [23:0]                    req_raw_temperature,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [14:0]             rsp_temperature_centi,
   output logic [16:0]                    rsp_pressure_pascal,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0] csr_data
);

   bsc_pkg::coef_type  coef_ff, coef_in;
   logic               front_valid, front_stall;
   bsc_pkg::front_type front_data;
   logic               corr_valid, corr_stall;
   bsc_pkg::corr_type  corr_data;

   // Calibration registers
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bsc_pkg::CSR_SENS:        coef_in.sens        = csr_data;
            bsc_pkg::CSR_OFFSET:      coef_in.offset      = csr_data;
            bsc_pkg::CSR_SENS_TEMP:   coef_in.sens_temp   = csr_data;
            bsc_pkg::CSR_OFFSET_TEMP: coef_in.offset_temp = csr_data;
            bsc_pkg::CSR_REF_TEMP:    coef_in.ref_temp    = csr_data;
            bsc_pkg::CSR_TEMP_SLOPE:  coef_in.temp_slope  = csr_data;
            default:                  coef_in             = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign csr_ready = 1'b1;

   bsc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .coef               (coef_ff),
      .in_valid           (req_valid),
      .in_stall           (req_stall),
      .in_raw_pressure    (req_raw_pressure),
      .in_raw_temperature (req_raw_temperature),
      .out_valid          (front_valid),
      .out_stall          (front_stall),
      .out_data           (front_data)
   );

   bsc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (corr_valid),
      .out_stall (corr_stall),
      .out_data  (corr_data)
   );

   bsc_press u_press (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (corr_valid),
      .in_stall              (corr_stall),
      .in_data               (corr_data),
      .out_valid             (rsp_valid),
      .out_stall             (rsp_stall),
      .out_temperature_centi (rsp_temperature_centi),
      .out_pressure_pascal   (rsp_pressure_pascal)
   );

endmodule

/* rtl/core/bsc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [14:0]             rsp_temperature_centi,
   input logic [16:0]                    rsp_pressure_pascal
);

   // A held result word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_temperature_centi) && $stable(rsp_pressure_pascal))
      else $error("result word changed while stalled");

   // Temperature always inside the clamp range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_centi >= 15'(bsc_pkg::TEMP_MIN)
         && rsp_temperature_centi <= 15'(bsc_pkg::TEMP_MAX))
      else $error("temperature outside clamp range");

   // Pressure always inside the clamp range
   a_pres_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pressure_pascal >= 17'(bsc_pkg::PRES_MIN)
         && rsp_pressure_pascal <= 17'(bsc_pkg::PRES_MAX))
      else $error("pressure outside clamp range");

   // The input only backs up when the pipe is full behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // Nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_temperature_centi (rsp_temperature_centi),
   .rsp_pressure_pascal   (rsp_pressure_pascal)
);
